/* rtl/vn_pkg.sv */
// Package with shared constants and types of the vector normalizer.
package vn_pkg;

    // Default sizes of the components and of the result fraction.
    localparam int unsigned DefComponentBits  = 16;
    localparam int unsigned DefResultFracBits = 15;

    // Side information that travels alongside the arithmetic lanes.
    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
        logic       last;
    } vn_side_t;

endpackage

/* rtl/vector4_normalizer_unit.sv */
// Pipeline: square and sum stages, the divider stages, the square root stages, then an output register.
// Throughput: one vector per cycle; every stage holds one item and all stages advance together.
// The depth is set by the divider (one quotient bit per stage) and the square root (one bit per stage).
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears only the valid bits; data registers are not reset.
module vector4_normalizer_unit
    import vn_pkg::*;
#(
    parameter int unsigned COMPONENT_BITS   = DefComponentBits,
    parameter int unsigned RESULT_FRAC_BITS = DefResultFracBits
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COMPONENT_BITS-1:0] comp_x,
    input  logic signed [COMPONENT_BITS-1:0] comp_y,
    input  logic signed [COMPONENT_BITS-1:0] comp_z,
    input  logic signed [COMPONENT_BITS-1:0] comp_w,
    input  logic                             last_vector,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [RESULT_FRAC_BITS:0] norm_x,
    output logic signed [RESULT_FRAC_BITS:0] norm_y,
    output logic signed [RESULT_FRAC_BITS:0] norm_z,
    output logic signed [RESULT_FRAC_BITS:0] norm_w,
    output logic                             zero_vector,
    output logic                             last_out
);

    localparam int unsigned CB  = COMPONENT_BITS;
    localparam int unsigned FB  = RESULT_FRAC_BITS;
    localparam int unsigned QW  = 2 * FB + 1;
    localparam int unsigned DLY = QW + FB + 2;
    localparam int unsigned LAT = 1 + DLY + 1;

    logic             en;
    logic [LAT-1:0]   vld_reg;
    logic [CB-1:0]    raw   [0:3];
    logic [CB-1:0]    mag   [0:3];
    logic [3:0]       neg;
    logic [2*CB-1:0]  sq_reg   [0:3];
    logic [3:0]       neg_reg;
    logic             last_reg;
    logic [2*CB-1:0]  sqb_reg  [0:3];
    logic [2*CB:0]    sum_reg;
    vn_side_t         side_next;
    vn_side_t         side_reg [0:DLY-1];
    logic [QW-1:0]    quot  [0:3];
    logic [FB:0]      root  [0:3];
    logic [FB:0]      res   [0:3];
    logic [FB:0]      out_reg [0:3];
    logic             zero_reg;
    logic             lastq_reg;

    // The whole pipeline moves whenever the output stage is free or being drained.
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Magnitude and sign of each component.
    assign raw[0] = comp_x;
    assign raw[1] = comp_y;
    assign raw[2] = comp_z;
    assign raw[3] = comp_w;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = raw[i][CB-1];
            mag[i] = neg[i] ? (~raw[i] + CB'(1)) : raw[i];
        end
    end

    // Stage one squares, stage two sums; the divider needs each square and the sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i]  <= (2*CB)'(mag[i]) * (2*CB)'(mag[i]);
                sqb_reg[i] <= sq_reg[i];
            end
            neg_reg  <= neg;
            last_reg <= last_vector;
            sum_reg  <= (2*CB+1)'(sq_reg[0]) + (2*CB+1)'(sq_reg[1])
                      + (2*CB+1)'(sq_reg[2]) + (2*CB+1)'(sq_reg[3]);
        end
    end

    // Side information is registered alongside the sum and then delayed to the output.
    assign side_next.neg  = neg_reg;
    assign side_next.last = last_reg;
    assign side_next.zero = (sq_reg[0] == '0) && (sq_reg[1] == '0)
                         && (sq_reg[2] == '0) && (sq_reg[3] == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DLY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Four lanes: quotient sq * 2^(2FB) / sum, then its square root.
    genvar l;
    generate
        for (l = 0; l < 4; l++) begin : g_lane
            vn_div #(.CB(CB), .FB(FB)) u_div
            (
                .clk  (clk),
                .en   (en),
                .sq   (sqb_reg[l]),
                .sum  (sum_reg),
                .quot (quot[l])
            );

            vn_sqrt #(.FB(FB)) u_sqrt
            (
                .clk  (clk),
                .en   (en),
                .n    (quot[l]),
                .root (root[l])
            );
        end
    endgenerate

    // Saturate unit magnitude, apply the sign and clear the zero vector case.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            res[i] = root[i][FB] ? {1'b0, {FB{1'b1}}} : root[i];
            if (side_reg[DLY-1].zero)
            begin
                res[i] = '0;
            end
            else if (side_reg[DLY-1].neg[i])
            begin
                res[i] = ~res[i] + (FB+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                out_reg[i] <= res[i];
            end
            zero_reg  <= side_reg[DLY-1].zero;
            lastq_reg <= side_reg[DLY-1].last;
        end
    end

    assign out_valid   = vld_reg[LAT-1];
    assign norm_x      = out_reg[0];
    assign norm_y      = out_reg[1];
    assign norm_z      = out_reg[2];
    assign norm_w      = out_reg[3];
    assign zero_vector = zero_reg;
    assign last_out    = lastq_reg;

    // A zero vector gives all-zero components.
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_vector |-> norm_x == '0 && norm_y == '0 && norm_z == '0
                                     && norm_w == '0)
        else $error("zero vector with non-zero result");

    // Saturation is symmetric, so the most negative code never appears; checked on norm_x and norm_y.
    a_sym_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> norm_x != {1'b1, {FB{1'b0}}} && norm_y != {1'b1, {FB{1'b0}}})
        else $error("most negative code at output");

    // The input side is held back exactly when a result is waiting.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stage");

endmodule

/* rtl/vn_div.sv */
// Pipelined restoring divider: floor(sq * 2^(2*FB) / sum), one quotient bit per stage.
module vn_div
    import vn_pkg::*;
#(
    parameter int unsigned CB = DefComponentBits,
    parameter int unsigned FB = DefResultFracBits
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [2*CB-1:0]     sq,
    input  logic [2*CB:0]       sum,
    output logic [2*FB:0]       quot
);

    localparam int unsigned SW = 2 * CB + 1;
    localparam int unsigned QW = 2 * FB + 1;

    logic [SW-1:0] r_w [0:QW];
    logic [SW-1:0] d_w [0:QW];
    logic [QW-1:0] q_w [0:QW];

    // The dividend is sq shifted up by 2*FB; its upper part seeds the remainder.
    assign r_w[0] = SW'(sq >> 1);
    assign d_w[0] = sum;
    assign q_w[0] = '0;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [SW:0]   rs;
            logic          ge;
            logic [SW:0]   rn;
            logic [SW-1:0] r_reg;
            logic [SW-1:0] d_reg;
            logic [QW-1:0] q_reg;

            // Bring down the next dividend bit, then try the subtraction.
            assign rs = {r_w[k], (k == 0) ? sq[0] : 1'b0};
            assign ge = (rs >= {1'b0, d_w[k]});
            assign rn = ge ? (rs - {1'b0, d_w[k]}) : rs;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg <= rn[SW-1:0];
                    d_reg <= d_w[k];
                    q_reg <= {q_w[k][QW-2:0], ge};
                end
            end

            assign r_w[k+1] = r_reg;
            assign d_w[k+1] = d_reg;
            assign q_w[k+1] = q_reg;
        end
    endgenerate

    assign quot = q_w[QW];

endmodule

/* rtl/vn_sqrt.sv */
// Pipelined integer square root, one result bit per stage, shifts and subtracts only.
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int unsigned FB = DefResultFracBits
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [2*FB:0]   n,
    output logic [FB:0]     root
);

    localparam int unsigned RW = 2 * FB + 2;

    logic [RW-1:0] rem_w [0:FB+1];
    logic [FB:0]   q_w   [0:FB+1];

    assign rem_w[0] = {1'b0, n};
    assign q_w[0]   = '0;

    genvar k;
    generate
        for (k = 0; k <= FB; k++) begin : g_stage
            localparam int unsigned B = FB - k;
            logic [RW-1:0] d;
            logic          ge;
            logic [RW-1:0] rem_reg;
            logic [FB:0]   q_reg;

            // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B); lower bits of q are still zero.
            assign d  = (RW'(q_w[k]) << (B + 1)) | (RW'(1) << (2 * B));
            assign ge = (rem_w[k] >= d);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= ge ? (rem_w[k] - d) : rem_w[k];
                    q_reg   <= ge ? (q_w[k] | ((FB+1)'(1) << B)) : q_w[k];
                end
            end

            assign rem_w[k+1] = rem_reg;
            assign q_w[k+1]   = q_reg;
        end
    endgenerate

    assign root = q_w[FB+1];

endmodule
